// ===== rtl/single_wire_sensor_reader_macros.svh =====
// Assertion macros shared by the single-wire sensor reader RTL.
`ifndef SINGLE_WIRE_SENSOR_READER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_READER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swsr: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SWSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swsr: next-cycle check failed");

`endif

// ===== rtl/swsr_pkg.sv =====
// Shared types and constants for the single-wire sensor reader.
`default_nettype none

package swsr_pkg;

  // Sequencer phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_START_LOW = 3'd1;
  localparam logic [2:0] PH_ANSWER    = 3'd2;
  localparam logic [2:0] PH_ANS_HIGH  = 3'd3;
  localparam logic [2:0] PH_BIT_LOW   = 3'd4;
  localparam logic [2:0] PH_BIT_HIGH  = 3'd5;
  localparam logic [2:0] PH_BIT_DELAY = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TIMEOUT = 3'd3;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 16;

  // Reset values of the timing registers
  localparam logic [15:0] START_LOW_RST    = 16'd25000;
  localparam logic [7:0]  ANSWER_WAIT_RST  = 8'd27;
  localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd32;
  localparam logic [15:0] EDGE_TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  answer_wait_ticks;
    logic [7:0]  sample_delay_ticks;
    logic [15:0] edge_timeout_ticks;
  } swsr_cfg_t;

  typedef struct packed {
    logic drive_low;
    logic busy;
    logic done;
    logic responded;
    logic timed_out;
  } swsr_flags_t;

endpackage

`default_nettype wire

// ===== rtl/swsr_core.sv =====
// Read sequencer: timing counter, phase register and receive shift register.
`default_nettype none

module swsr_core import swsr_pkg::*; #(
  parameter int unsigned TOTAL_BITS = 40
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  command_i,
  input  wire logic                  line_level_i,
  input  wire swsr_cfg_t             cfg_i,
  output swsr_flags_t                flags_o,
  output logic [TOTAL_BITS-1:0]      shift_o
);

  localparam int unsigned BIT_W = $clog2(TOTAL_BITS + 1);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(TOTAL_BITS);

  logic [2:0]            phase_q, phase_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_inc;
  logic [BIT_W-1:0]      bit_q, bit_d, bit_inc;
  logic [TOTAL_BITS-1:0] shift_q, shift_d;
  logic                  resp_q, resp_d;
  logic                  tmo_q, tmo_d;
  logic                  done;
  logic                  edge_seen;
  logic                  timeout_hit;

  // Saturating tick count; a zero length acts as one tick
  assign cnt_inc     = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;
  assign timeout_hit = (cnt_inc >= cfg_i.edge_timeout_ticks);
  assign bit_inc     = bit_q + 1'b1;
  assign edge_seen   = (phase_q == PH_BIT_LOW) ? !line_level_i : line_level_i;

  // Advance the sequence by one tick
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    resp_d  = resp_q;
    tmo_d   = tmo_q;
    done    = 1'b0;
    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (command_i) begin
            shift_d = '0;
            bit_d   = '0;
            resp_d  = 1'b0;
            tmo_d   = 1'b0;
            phase_d = PH_START_LOW;
            cnt_d   = '0;
          end
        end
        PH_START_LOW: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.start_low_ticks) begin
            phase_d = PH_ANSWER;
            cnt_d   = '0;
          end
        end
        PH_ANSWER: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= {8'd0, cfg_i.answer_wait_ticks}) begin
            cnt_d = '0;
            if (!line_level_i) begin
              resp_d  = 1'b1;
              phase_d = PH_ANS_HIGH;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
        end
        PH_ANS_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
          if (edge_seen) begin
            cnt_d = '0;
            case (phase_q)
              PH_ANS_HIGH: phase_d = PH_BIT_LOW;
              PH_BIT_LOW:  phase_d = PH_BIT_HIGH;
              default:     phase_d = PH_BIT_DELAY;
            endcase
          end else begin
            cnt_d = cnt_inc;
            if (timeout_hit) begin
              tmo_d   = 1'b1;
              phase_d = PH_IDLE;
              cnt_d   = '0;
              done    = 1'b1;
            end
          end
        end
        PH_BIT_DELAY: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= {8'd0, cfg_i.sample_delay_ticks}) begin
            shift_d = {shift_q[TOTAL_BITS-2:0], line_level_i};
            bit_d   = bit_inc;
            cnt_d   = '0;
            if (bit_inc >= BIT_LAST) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              phase_d = PH_BIT_LOW;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      resp_q  <= 1'b0;
      tmo_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      resp_q  <= resp_d;
      tmo_q   <= tmo_d;
    end
  end

  // Report the state as it stands after this tick
  assign flags_o.drive_low = (phase_d == PH_START_LOW);
  assign flags_o.busy      = (phase_d != PH_IDLE);
  assign flags_o.done      = done;
  assign flags_o.responded = resp_d;
  assign flags_o.timed_out = tmo_d;
  assign shift_o           = shift_d;

endmodule

`default_nettype wire

// ===== rtl/single_wire_sensor_reader.sv =====
// Top level of the single-wire sensor reader: register file, handshakes, result register.
`default_nettype none
`include "single_wire_sensor_reader_macros.svh"

// Host side of a single-wire temperature/humidity sensor read. Each input
// transfer is one microsecond tick carrying the sampled line level and an
// optional start request; every tick yields exactly one result transfer with
// the line drive, busy/done status, the answer and timeout flags and the bits
// received so far (data above, checksum below, MSB first). The sequencer
// state updates in the accepting cycle and the result lands in an output
// register, so a new tick is taken every cycle while the result side keeps
// up; the output register is the only buffering, and a stalled result holds
// off the next tick. The four timing registers are written on the
// configuration channel, which is always ready, and should be changed only
// while no reading is running and no result is pending.
module single_wire_sensor_reader import swsr_pkg::*; #(
  parameter int unsigned DATA_BITS  = 32,
  parameter int unsigned CHECK_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  command_i,
  input  wire logic                  line_level_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       drive_low_o,
  output logic                       busy_res_o,
  output logic                       done_res_o,
  output logic                       responded_o,
  output logic                       timed_out_o,
  output logic [DATA_BITS-1:0]       data_word_o,
  output logic [CHECK_BITS-1:0]      checksum_byte_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned TOTAL_BITS = DATA_BITS + CHECK_BITS;

  swsr_cfg_t             cfg_q;
  swsr_flags_t           flags_d, flags_q;
  logic [TOTAL_BITS-1:0] shift_d, shift_q;
  logic                  out_valid_q;
  logic                  in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks    <= START_LOW_RST;
      cfg_q.answer_wait_ticks  <= ANSWER_WAIT_RST;
      cfg_q.sample_delay_ticks <= SAMPLE_DELAY_RST;
      cfg_q.edge_timeout_ticks <= EDGE_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_LOW:    cfg_q.start_low_ticks    <= cfg_data_i;
        CFG_ANSWER_WAIT:  cfg_q.answer_wait_ticks  <= cfg_data_i[7:0];
        CFG_SAMPLE_DELAY: cfg_q.sample_delay_ticks <= cfg_data_i[7:0];
        CFG_EDGE_TIMEOUT: cfg_q.edge_timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  swsr_core #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_xfer),
    .command_i    (command_i),
    .line_level_i (line_level_i),
    .cfg_i        (cfg_q),
    .flags_o      (flags_d),
    .shift_o      (shift_d)
  );

  // Hold the result until the downstream transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      flags_q <= flags_d;
      shift_q <= shift_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_low_o     = flags_q.drive_low;
  assign busy_res_o      = flags_q.busy;
  assign done_res_o      = flags_q.done;
  assign responded_o     = flags_q.responded;
  assign timed_out_o     = flags_q.timed_out;
  assign data_word_o     = shift_q[TOTAL_BITS-1:CHECK_BITS];
  assign checksum_byte_o = shift_q[CHECK_BITS-1:0];

  // A finished reading is never reported as still running
  `SWSR_ASSERT_IMP(a_done_not_busy, out_valid_o && done_res_o, !busy_res_o)
  // Driving low only happens in the start phase, before any answer or timeout
  `SWSR_ASSERT_IMP(a_drive_start_only, out_valid_o && drive_low_o,
                   busy_res_o && !responded_o && !timed_out_o)
  // A timeout can only follow the sensor's answer
  `SWSR_ASSERT_IMP(a_timeout_after_answer, out_valid_o && timed_out_o, responded_o)
  // Every accepted tick leaves a result behind
  `SWSR_ASSERT_NXT(a_tick_gives_result, in_valid_i && in_ready_o, out_valid_o)

endmodule

`default_nettype wire

// ===== bench/tb_single_wire_sensor_reader.sv =====
// Self-checking testbench for the single-wire sensor reader: directed, extreme and random reads.
`default_nettype none

module tb_single_wire_sensor_reader;
  import swsr_pkg::*;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CHECK_W    = 8;
  localparam int unsigned FRAME_BITS = DATA_W + CHECK_W;
  localparam int unsigned RANDOM_TICKS = 400;
  localparam longint unsigned SIM_LIMIT = 64'd4_000_000;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic                drive_low;
    logic                busy;
    logic                done;
    logic                responded;
    logic                timed_out;
    logic [DATA_W-1:0]   data_word;
    logic [CHECK_W-1:0]  checksum;
  } readout_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  // Block inputs, all known from time zero
  logic                  in_valid_i   = 1'b0;
  logic                  command_i    = 1'b0;
  logic                  line_level_i = 1'b0;
  logic                  out_ready_i  = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = CFG_START_LOW;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  // Block outputs
  logic               in_ready_o;
  logic               out_valid_o;
  logic               drive_low_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic               responded_o;
  logic               timed_out_o;
  logic [DATA_W-1:0]  data_word_o;
  logic [CHECK_W-1:0] checksum_byte_o;
  logic               cfg_ready_o;

  single_wire_sensor_reader #(
    .DATA_BITS  (DATA_W),
    .CHECK_BITS (CHECK_W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .line_level_i    (line_level_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_low_o     (drive_low_o),
    .busy_res_o      (busy_res_o),
    .done_res_o      (done_res_o),
    .responded_o     (responded_o),
    .timed_out_o     (timed_out_o),
    .data_word_o     (data_word_o),
    .checksum_byte_o (checksum_byte_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Timing registers as the block should hold them
  logic [15:0] cfg_start_low    = START_LOW_RST;
  logic [7:0]  cfg_answer_wait  = ANSWER_WAIT_RST;
  logic [7:0]  cfg_sample_delay = SAMPLE_DELAY_RST;
  logic [15:0] cfg_edge_timeout = EDGE_TIMEOUT_RST;

  // Sequencer state as the block should hold it
  logic [2:0]            seq_phase = PH_IDLE;
  logic [15:0]           seq_wait  = '0;
  logic [5:0]            seq_bits  = '0;
  logic [FRAME_BITS-1:0] seq_shift = '0;
  logic                  seq_resp  = 1'b0;
  logic                  seq_tmo   = 1'b0;

  readout_t pending_readouts[$];
  readout_t head_readout;
  int       ticks_sent     = 0;
  int       mismatch_count = 0;
  int       stall_left     = 0;
  int       idle_stop      = 0;
  bit       idle_en        = 1'b0;

  // ---------------------------------------------------------------------------
  // Sequencer prediction
  // ---------------------------------------------------------------------------

  function automatic void enter_phase(input logic [2:0] next);
    seq_phase = next;
    seq_wait  = '0;
  endfunction

  // Count one tick, saturating; a wait of zero ends after one tick
  function automatic bit wait_elapsed(input logic [15:0] ticks);
    if (seq_wait != 16'hFFFF) seq_wait = seq_wait + 16'd1;
    return seq_wait >= ticks;
  endfunction

  // Advance on the expected edge or abort on timeout; true when the read ends
  function automatic bit await_edge(input logic seen, input logic [2:0] next);
    if (seen) begin
      enter_phase(next);
      return 1'b0;
    end
    if (wait_elapsed(cfg_edge_timeout)) begin
      seq_tmo = 1'b1;
      enter_phase(PH_IDLE);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic readout_t advance_sequencer(input logic start, input logic lvl);
    readout_t r;
    logic     finished;
    finished = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (start) begin
          seq_shift = '0;
          seq_bits  = '0;
          seq_resp  = 1'b0;
          seq_tmo   = 1'b0;
          enter_phase(PH_START_LOW);
        end
      end
      PH_START_LOW: begin
        if (wait_elapsed(cfg_start_low)) enter_phase(PH_ANSWER);
      end
      PH_ANSWER: begin
        if (wait_elapsed({8'd0, cfg_answer_wait})) begin
          if (!lvl) begin
            seq_resp = 1'b1;
            enter_phase(PH_ANS_HIGH);
          end else begin
            enter_phase(PH_IDLE);
            finished = 1'b1;
          end
        end
      end
      PH_ANS_HIGH:  finished = await_edge(lvl, PH_BIT_LOW);
      PH_BIT_LOW:   finished = await_edge(!lvl, PH_BIT_HIGH);
      PH_BIT_HIGH:  finished = await_edge(lvl, PH_BIT_DELAY);
      PH_BIT_DELAY: begin
        if (wait_elapsed({8'd0, cfg_sample_delay})) begin
          seq_shift = {seq_shift[FRAME_BITS-2:0], lvl};
          seq_bits  = seq_bits + 6'd1;
          if (seq_bits >= FRAME_BITS) begin
            enter_phase(PH_IDLE);
            finished = 1'b1;
          end else begin
            enter_phase(PH_BIT_LOW);
          end
        end
      end
      default: enter_phase(PH_IDLE);
    endcase
    r.drive_low = (seq_phase == PH_START_LOW);
    r.busy      = (seq_phase != PH_IDLE);
    r.done      = finished;
    r.responded = seq_resp;
    r.timed_out = seq_tmo;
    r.data_word = seq_shift[FRAME_BITS-1:CHECK_W];
    r.checksum  = seq_shift[CHECK_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tick sender and register writes
  // ---------------------------------------------------------------------------

  // Offer one tick, with an occasional idle burst first, and log its readout
  task automatic send_tick(input logic cmd, input logic lvl);
    // no idling once the closing stretch is reached
    if (ticks_sent >= idle_stop) idle_en = 1'b0;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    line_level_i <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_readouts.push_back(advance_sequencer(cmd, lvl));
    ticks_sent++;
  endtask

  // Hold off new ticks until every logged readout has come back
  task automatic await_all_readouts();
    in_valid_i <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
  endtask

  // Leaves the write channel valid; the caller drops it after the last transfer
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_START_LOW:    cfg_start_low    = data;
      CFG_ANSWER_WAIT:  cfg_answer_wait  = data[7:0];
      CFG_SAMPLE_DELAY: cfg_sample_delay = data[7:0];
      CFG_EDGE_TIMEOUT: cfg_edge_timeout = data;
      default: ;
    endcase
  endtask

  // Reprogram all timing registers; callers only do this between reads
  task automatic apply_timing(input logic [15:0] start_low, input logic [15:0] answer_wait,
                              input logic [15:0] sample_delay, input logic [15:0] edge_timeout);
    await_all_readouts();
    repeat (2) @(posedge clk_i);
    write_register(CFG_START_LOW, start_low);
    write_register(CFG_ANSWER_WAIT, answer_wait);
    write_register(CFG_SAMPLE_DELAY, sample_delay);
    write_register(CFG_EDGE_TIMEOUT, edge_timeout);
    if ($urandom_range(0, 3) == 0) write_register(CFG_SPARE, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Play the sensor for one read. From bit stall_at on the sensor goes silent;
  // noise_pct flips the line at random to break the sequence.
  task automatic run_reading(input logic [FRAME_BITS-1:0] frame, input bit answer,
                             input int stall_at, input int noise_pct);
    logic lvl;
    logic cmd;
    bit   silent;
    bit   hit;
    int   limit;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (seq_phase != PH_IDLE) begin
      cmd    = ($urandom_range(0, 3) == 0);
      silent = (int'(seq_bits) >= stall_at);
      limit  = (cfg_edge_timeout == 16'd0) ? 1 : int'(cfg_edge_timeout);
      // give the edge at random, but always before the timeout would fire
      hit    = !silent && ((int'(seq_wait) + 1 >= limit) || $urandom_range(0, 1) == 1);
      case (seq_phase)
        PH_ANSWER:    lvl = !answer;
        PH_ANS_HIGH:  lvl = hit;
        PH_BIT_LOW:   lvl = !hit;
        PH_BIT_HIGH:  lvl = hit;
        PH_BIT_DELAY: lvl = frame[FRAME_BITS-1-seq_bits];
        default:      lvl = 1'($urandom_range(0, 1));
      endcase
      if ($urandom_range(0, 99) < noise_pct) lvl = !lvl;
      send_tick(cmd, lvl);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Readout checking and result-side stalls
  // ---------------------------------------------------------------------------

  function automatic void report_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readouts.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected readout, expected none, got data %0h",
                 $time, data_word_o);
      end else begin
        head_readout = pending_readouts.pop_front();
        report_field("drive_low", head_readout.drive_low, drive_low_o);
        report_field("busy", head_readout.busy, busy_res_o);
        report_field("done", head_readout.done, done_res_o);
        report_field("responded", head_readout.responded, responded_o);
        report_field("timed_out", head_readout.timed_out, timed_out_o);
        report_field("data_word", head_readout.data_word, data_word_o);
        report_field("checksum", head_readout.checksum, checksum_byte_o);
      end
    end
    // Stall the result side in random bursts while idling is enabled
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset answer wait and sample delay, with a short start pulse and timeout
  task automatic test_reset_timing();
    idle_en = 1'b0;
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    await_all_readouts();
    write_register(CFG_START_LOW, 16'd3);
    write_register(CFG_EDGE_TIMEOUT, 16'd6);
    cfg_valid_i <= 1'b0;
    run_reading({8'($urandom), 32'($urandom)}, 1'b0, FRAME_BITS, 0);
    run_reading({8'($urandom), 32'($urandom)}, 1'b1, 2, 0);
  endtask

  // Hand-built ticks with every delay at zero
  task automatic test_directed_cases();
    apply_timing(16'd0, 16'd0, 16'd0, 16'd0);
    // answered read: two bits, then timeout while waiting for a falling edge
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);   // start while busy is ignored
    send_tick(1'b0, 1'b0);   // sensor answers low
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);   // bit sampled high
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);   // bit sampled low
    send_tick(1'b0, 1'b1);   // no falling edge: timeout with partial data
    send_tick(1'b0, 1'b1);
    // no answer from the sensor
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    // answer, but the line never rises again
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  // Longest answer and sample waits, written with every data bit set
  task automatic test_timing_extremes();
    idle_en = 1'b0;
    apply_timing(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
    run_reading({8'($urandom), 32'($urandom)}, 1'b1, 1, 0);
  endtask

  // Short random timings; mostly clean reads, some broken ones
  task automatic test_random_readings();
    int first_tick;
    first_tick = ticks_sent;
    idle_stop  = first_tick + int'(RANDOM_TICKS * 4 / 5);
    while (ticks_sent - first_tick < RANDOM_TICKS) begin
      idle_en = (ticks_sent < idle_stop) && ($urandom_range(0, 3) != 0);
      apply_timing(16'($urandom_range(0, 4)),
                   {8'($urandom), 8'($urandom_range(0, 4))},
                   {8'($urandom), 8'($urandom_range(0, 4))},
                   16'($urandom_range(0, 8)));
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0)
          run_reading({8'($urandom), 32'($urandom)}, 1'b1, FRAME_BITS, 0);
        else
          run_reading({8'($urandom), 32'($urandom)}, $urandom_range(0, 3) != 0,
                      $urandom_range(0, FRAME_BITS + 4), $urandom_range(0, 20));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_timing();
    test_directed_cases();
    test_timing_extremes();
    test_random_readings();
    await_all_readouts();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(SIM_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
